// ===== rtl/bbs_pkg.sv =====
// bbs_pkg: shared types and constants for the bouncing ball box step block.
// Register map, op codes, word layouts, reset values and the multiplier request.
// No dependencies.
package bbs_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 27;

   localparam int OP_W       = 2;
   localparam int LAUNCH_W   = 19;
   localparam int REQ_DATA_W = 40;

   localparam int POS_OUT_W  = 26;
   localparam int VEL_W      = 27;
   localparam int RSP_USED_W = 3 * POS_OUT_W + 3 * VEL_W + 2;
   localparam int RSP_DATA_W = 168;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 17;

   localparam logic signed [VEL_W-1:0] VEL_LIMIT = 27'sd33554432;
   localparam int DROP_HEIGHT = 5;

   localparam logic [CSR_ADDR_W-1:0] REG_GRAVITY  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BOUNCE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BOX      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RADIUS   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_REST     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LAUNCH   = 3'd6;

   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_TOGGLE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RELAUNCH = 2'd2;

   localparam logic signed [26:0] RST_GRAVITY = -27'sd642253;
   localparam logic [16:0] RST_STEP   = 17'd1049;
   localparam logic [16:0] RST_BOUNCE = 17'd49152;
   localparam logic [25:0] RST_BOX    = 26'd6553600;
   localparam logic [24:0] RST_RADIUS = 25'd262144;
   localparam logic [25:0] RST_REST   = 26'd65536;
   localparam logic [25:0] RST_LAUNCH = 26'd1310720;

   typedef struct packed {
      logic signed [26:0] gravity_accel;
      logic [16:0]        time_step;
      logic [16:0]        bounce_factor;
      logic [25:0]        box_size;
      logic [24:0]        ball_radius;
      logic [25:0]        rest_speed;
      logic [25:0]        launch_speed;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gravity_accel: RST_GRAVITY,
      time_step:     RST_STEP,
      bounce_factor: RST_BOUNCE,
      box_size:      RST_BOX,
      ball_radius:   RST_RADIUS,
      rest_speed:    RST_REST,
      launch_speed:  RST_LAUNCH
   };

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

endpackage

// ===== rtl/bbs_csr.sv =====
// bbs_csr: configuration register file of the bouncing ball box step block.
// Write-only, one register per index. Depends on bbs_pkg.
module bbs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bbs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bbs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bbs_pkg::cfg_type                cfg
);
   import bbs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_GRAVITY: begin
               cfg_in.gravity_accel = signed'(csr_wdata[26:0]);
            end
            REG_STEP: begin
               cfg_in.time_step = csr_wdata[16:0];
            end
            REG_BOUNCE: begin
               cfg_in.bounce_factor = csr_wdata[16:0];
            end
            REG_BOX: begin
               cfg_in.box_size = csr_wdata[25:0];
            end
            REG_RADIUS: begin
               cfg_in.ball_radius = csr_wdata[24:0];
            end
            REG_REST: begin
               cfg_in.rest_speed = csr_wdata[25:0];
            end
            REG_LAUNCH: begin
               cfg_in.launch_speed = csr_wdata[25:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bbs_mul.sv =====
// bbs_mul: bit-serial signed x unsigned fixed point multiplier, one multiplier
// bit per cycle, result rounded half away from zero and scaled down. Depends on bbs_pkg.
module bbs_mul #(
   parameter int FRAC_BITS = 16,
   localparam int PROD_W = bbs_pkg::MUL_A_W + bbs_pkg::MUL_B_W + 1 - FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bbs_pkg::mul_req_type     req,
   output logic                     done,
   output logic signed [PROD_W-1:0] prod
);
   import bbs_pkg::*;

   localparam int ACC_W = MUL_A_W + MUL_B_W + 1;
   localparam int HI_W  = MUL_A_W + 1;
   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [1:0] {M_IDLE, M_SHIFT, M_ROUND, M_SIGN} state_type;

   state_type                 state_ff, state_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [MUL_A_W-1:0]        amag_ff, amag_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [HI_W-1:0]           hi_sum;
   logic signed [PROD_W-1:0]  mag;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      amag_in  = amag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      hi_sum   = acc_ff[ACC_W-1:MUL_B_W] + (acc_ff[0] ? {1'b0, amag_ff} : HI_W'(0));
      mag      = signed'(acc_ff[ACC_W-1:FRAC_BITS]);
      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               amag_in  = req.a[MUL_A_W-1] ? MUL_A_W'(-req.a) : MUL_A_W'(req.a);
               neg_in   = req.a[MUL_A_W-1];
               acc_in   = {HI_W'(0), req.b};
               cnt_in   = '0;
               state_in = M_SHIFT;
            end
         end
         M_SHIFT: begin
            acc_in = {hi_sum, acc_ff[MUL_B_W-1:0]} >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
               state_in = M_ROUND;
            end
         end
         M_ROUND: begin
            acc_in   = acc_ff + HALF;
            state_in = M_SIGN;
         end
         M_SIGN: begin
            prod_in  = neg_ff ? -mag : mag;
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff  <= acc_in;
      amag_ff <= amag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ===== rtl/bouncing_ball_box_step.sv =====
// Bouncing ball box step: one ball in a cube, signed fixed point with FRAC_BITS fraction
// bits. A toggle, a relaunch, a tick of a stopped ball or an unused op goes straight to
// the done state. A tick of a running ball runs four products (gravity and three moves)
// and one more per wall hit that bounces, through a single bit-serial multiplier, and
// checks the walls one by one.
// The next word is taken once the previous one has been handed to the output register.
// Depends on bbs_pkg, bbs_csr and bbs_mul.
module bouncing_ball_box_step #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // launch_vx [18:0], launch_vy [37:19], zero fill
   input  logic [bbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op [1:0]
   input  logic [bbs_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // ball_x, ball_y, ball_z, speed_x, speed_y, speed_z, running, came_to_rest, zero fill
   output logic [bbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [bbs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bbs_pkg::*;

   localparam int POS_W  = (WORD_BITS > 28) ? WORD_BITS : 28;
   localparam int PROD_W = MUL_A_W + MUL_B_W + 1 - FRAC_BITS;
   localparam int VSUM_W = ((VEL_W > PROD_W) ? VEL_W : PROD_W) + 1;
   localparam int PSUM_W = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;
   localparam int CMP_W  = POS_W + 2;
   localparam logic signed [PSUM_W-1:0] POS_HI =
      {{(PSUM_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
   localparam logic signed [PSUM_W-1:0] POS_LO = ~POS_HI;
   localparam logic signed [POS_W-1:0] RST_HALF = signed'(POS_W'(RST_BOX >> 1));
   localparam logic signed [POS_W-1:0] RST_POS_Z =
      signed'(POS_W'(RST_RADIUS) + (POS_W'(DROP_HEIGHT) << FRAC_BITS));

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // odd codes are upper walls
   localparam logic [2:0] WALL_FLOOR = 3'd0;
   localparam logic [2:0] WALL_CEIL  = 3'd1;
   localparam logic [2:0] WALL_X_LO  = 3'd2;
   localparam logic [2:0] WALL_X_HI  = 3'd3;
   localparam logic [2:0] WALL_Y_LO  = 3'd4;
   localparam logic [2:0] WALL_Y_HI  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_GRAV_GO, ST_GRAV_WAIT, ST_MOVE_GO, ST_MOVE_WAIT, ST_WALL, ST_REFL_WAIT,
      ST_DONE
   } state_type;

   function automatic logic [1:0] wall_axis(input logic [2:0] w);
      case (w)
         WALL_FLOOR, WALL_CEIL: wall_axis = AXIS_Z;
         WALL_X_LO, WALL_X_HI:  wall_axis = AXIS_X;
         default:               wall_axis = AXIS_Y;
      endcase
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VSUM_W-1:0] v);
      if (v > VSUM_W'(VEL_LIMIT)) begin
         sat_vel = VEL_LIMIT;
      end else if (v < -VSUM_W'(VEL_LIMIT)) begin
         sat_vel = -VEL_LIMIT;
      end else begin
         sat_vel = VEL_W'(v);
      end
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_launch(input logic [25:0] s);
      if ({1'b0, s} > VEL_LIMIT) begin
         sat_launch = VEL_LIMIT;
      end else begin
         sat_launch = signed'({1'b0, s});
      end
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PSUM_W-1:0] v);
      if (v > POS_HI) begin
         sat_pos = POS_W'(POS_HI);
      end else if (v < POS_LO) begin
         sat_pos = POS_W'(POS_LO);
      end else begin
         sat_pos = POS_W'(v);
      end
   endfunction

   function automatic logic [POS_OUT_W-1:0] out_pos(input logic signed [POS_W-1:0] p);
      if (p[POS_W-1]) begin
         out_pos = '0;
      end else if (|p[POS_W-2:POS_OUT_W]) begin
         out_pos = '1;
      end else begin
         out_pos = p[POS_OUT_W-1:0];
      end
   endfunction

   cfg_type                   cfg;
   mul_req_type               mul_req;
   logic                      mul_done;
   logic signed [PROD_W-1:0]  mul_p;

   state_type                 state_ff, state_in;
   logic [2:0]                wall_ff, wall_in;
   logic [1:0]                axis_ff, axis_in;
   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [POS_W-1:0]   pos_in [3];
   logic signed [VEL_W-1:0]   vel_ff [3];
   logic signed [VEL_W-1:0]   vel_in [3];
   logic                      run_ff, run_in;
   logic                      rest_ff, rest_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic signed [POS_W-1:0]   pos_cur;
   logic signed [VEL_W-1:0]   vel_cur;
   logic signed [CMP_W-1:0]   pos_cmp, rad_cmp, box_cmp;
   logic                      lo_hit, hi_hit, wall_hit;
   logic [26:0]               top_diff;
   logic signed [POS_W-1:0]   top_pos, rad_pos, half_box;
   logic [VEL_W-1:0]          vz_abs;
   logic                      vz_slow;
   logic                      wall_last;
   logic [2:0]                wall_nxt;

   bbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bbs_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_p)
   );

   always_comb begin
      pos_cur   = pos_ff[axis_ff];
      vel_cur   = vel_ff[axis_ff];
      pos_cmp   = CMP_W'(pos_cur);
      rad_cmp   = signed'(CMP_W'(cfg.ball_radius));
      box_cmp   = signed'(CMP_W'(cfg.box_size));
      lo_hit    = pos_cmp < rad_cmp;
      hi_hit    = (pos_cmp + rad_cmp) > box_cmp;
      wall_hit  = wall_ff[0] ? hi_hit : lo_hit;
      top_diff  = {1'b0, cfg.box_size} - 27'(cfg.ball_radius);
      top_pos   = top_diff[26] ? '0 : signed'(POS_W'(top_diff[25:0]));
      rad_pos   = signed'(POS_W'(cfg.ball_radius));
      half_box  = signed'(POS_W'(cfg.box_size >> 1));
      vz_abs    = vel_ff[AXIS_Z][VEL_W-1] ? VEL_W'(-vel_ff[AXIS_Z]) : VEL_W'(vel_ff[AXIS_Z]);
      vz_slow   = vz_abs < VEL_W'(cfg.rest_speed);
      wall_last = wall_ff == WALL_Y_HI;
      wall_nxt  = wall_ff + 3'd1;
   end

   always_comb begin
      state_in     = state_ff;
      wall_in      = wall_ff;
      axis_in      = axis_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      run_in       = run_ff;
      rest_in      = rest_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_req.start = 1'b0;
      mul_req.a     = vel_cur;
      mul_req.b     = cfg.time_step;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rest_in  = 1'b0;
               state_in = ST_DONE;
               case (req_tuser)
                  OP_TICK: begin
                     if (run_ff) begin
                        state_in = ST_GRAV_GO;
                     end
                  end
                  OP_TOGGLE: begin
                     run_in = ~run_ff;
                  end
                  OP_RELAUNCH: begin
                     pos_in[AXIS_X] = half_box;
                     pos_in[AXIS_Y] = half_box;
                     pos_in[AXIS_Z] = rad_pos + (POS_W'(DROP_HEIGHT) << FRAC_BITS);
                     vel_in[AXIS_X] = VEL_W'(signed'(req_tdata[LAUNCH_W-1:0]));
                     vel_in[AXIS_Y] = VEL_W'(signed'(req_tdata[2*LAUNCH_W-1:LAUNCH_W]));
                     vel_in[AXIS_Z] = sat_launch(cfg.launch_speed);
                     run_in         = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GRAV_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = cfg.gravity_accel;
            state_in      = ST_GRAV_WAIT;
         end
         ST_GRAV_WAIT: begin
            if (mul_done) begin
               vel_in[AXIS_Z] = sat_vel(VSUM_W'(vel_ff[AXIS_Z]) + VSUM_W'(mul_p));
               axis_in        = AXIS_X;
               state_in       = ST_MOVE_GO;
            end
         end
         ST_MOVE_GO: begin
            mul_req.start = 1'b1;
            state_in      = ST_MOVE_WAIT;
         end
         ST_MOVE_WAIT: begin
            if (mul_done) begin
               pos_in[axis_ff] = sat_pos(PSUM_W'(pos_cur) + PSUM_W'(mul_p));
               if (axis_ff == AXIS_Z) begin
                  wall_in  = WALL_FLOOR;
                  state_in = ST_WALL;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MOVE_GO;
               end
            end
         end
         ST_WALL: begin
            if (wall_hit) begin
               pos_in[axis_ff] = wall_ff[0] ? top_pos : rad_pos;
               if (wall_ff == WALL_FLOOR && vz_slow) begin
                  vel_in[AXIS_X] = '0;
                  vel_in[AXIS_Y] = '0;
                  vel_in[AXIS_Z] = '0;
                  run_in         = 1'b0;
                  rest_in        = 1'b1;
                  state_in       = ST_DONE;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.b     = cfg.bounce_factor;
                  state_in      = ST_REFL_WAIT;
               end
            end else if (wall_last) begin
               state_in = ST_DONE;
            end else begin
               wall_in = wall_nxt;
               axis_in = wall_axis(wall_nxt);
            end
         end
         ST_REFL_WAIT: begin
            if (mul_done) begin
               vel_in[axis_ff] = sat_vel(-(VSUM_W'(mul_p)));
               if (wall_last) begin
                  state_in = ST_DONE;
               end else begin
                  wall_in  = wall_nxt;
                  axis_in  = wall_axis(wall_nxt);
                  state_in = ST_WALL;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = {RSP_PAD_W'(0), rest_ff, run_ff,
                              vel_ff[AXIS_Z], vel_ff[AXIS_Y], vel_ff[AXIS_X],
                              out_pos(pos_ff[AXIS_Z]), out_pos(pos_ff[AXIS_Y]),
                              out_pos(pos_ff[AXIS_X])};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wall_ff        <= WALL_FLOOR;
         axis_ff        <= AXIS_X;
         pos_ff[AXIS_X] <= RST_HALF;
         pos_ff[AXIS_Y] <= RST_HALF;
         pos_ff[AXIS_Z] <= RST_POS_Z;
         vel_ff[AXIS_X] <= '0;
         vel_ff[AXIS_Y] <= '0;
         vel_ff[AXIS_Z] <= sat_launch(RST_LAUNCH);
         run_ff         <= 1'b0;
         rest_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wall_ff      <= wall_in;
         axis_ff      <= axis_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         run_ff       <= run_in;
         rest_ff      <= rest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/bbs_check.sv =====
// bbs_check: port-level checks for the bouncing ball box step block, and the bind
// that attaches them to the top level. Depends on bbs_pkg.
module bbs_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [bbs_pkg::OP_W-1:0]        req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            csr_we,
   input logic [bbs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input logic [bbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bbs_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser, csr_we, csr_addr, csr_wdata};

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // one word in flight: input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in flight");

   // a rest stop leaves the ball stopped and motionless
   a_rest_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[160] |-> !rsp_tdata[159] && rsp_tdata[158:78] == 81'd0)
      else $error("rest stop with motion or run flag");

   // vertical speed stays inside the saturation band
   a_vz_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[158:132]) <= VEL_LIMIT &&
                     $signed(rsp_tdata[158:132]) >= -VEL_LIMIT)
      else $error("speed_z outside saturation band");

endmodule

bind bouncing_ball_box_step bbs_check u_bbs_check (.*);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for bouncing_ball_box_step. Drives op words and register
// writes, predicts each result word from its own fixed-point ball model or a table of known words and checks them.
// Depends on bbs_pkg and the bouncing_ball_box_step RTL.
module testbench;
   import bbs_pkg::*;

   localparam int FRAC = 16;
   localparam longint SPEED_MAX = 64'sd33554432;
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint POS_LO = -POS_HI - 1;
   localparam longint REPORT_MAX = 64'sd67108863;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int STALL_LIMIT = 8000;
   localparam int LONG_HOLD = 900;
   localparam int SETTLE = 4;
   localparam int TAIL = 300;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 52;

   // result word, ball_x in the lowest bits
   typedef struct packed {
      logic               came_to_rest;
      logic               running;
      logic signed [26:0] speed_z;
      logic signed [26:0] speed_y;
      logic signed [26:0] speed_x;
      logic [25:0]        ball_z;
      logic [25:0]        ball_y;
      logic [25:0]        ball_x;
   } ball_word_t;

   localparam int NO_KNOWN = -1;
   localparam int KNOWN_START = 0;
   localparam int KNOWN_RELAUNCH = 1;
   localparam ball_word_t KNOWN_WORDS [2] = '{
      '{came_to_rest: 1'b0, running: 1'b1, speed_z: 27'sd1310720, speed_y: 27'sd0,
        speed_x: 27'sd0, ball_z: 26'd589824, ball_y: 26'd3276800, ball_x: 26'd3276800},
      '{came_to_rest: 1'b0, running: 1'b0, speed_z: 27'sd1310720, speed_y: -27'sd131072,
        speed_x: 27'sd131072, ball_z: 26'd589824, ball_y: 26'd3276800, ball_x: 26'd3276800}
   };

   typedef struct packed {
      bit                    is_reg;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      logic [OP_W-1:0]       op;
      logic [LAUNCH_W-1:0]   vx;
      logic [LAUNCH_W-1:0]   vy;
      int                    known;
   } plan_row_t;

   localparam int PLAN_LEN = 38;
   localparam plan_row_t PLAN [PLAN_LEN] = '{
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 5, -7, KNOWN_START},
      '{0, REG_GRAVITY, 0, OP_SPARE, -131072, 131072, KNOWN_START},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_RELAUNCH, 131072, -131072, KNOWN_RELAUNCH},
      '{1, REG_STEP, 65536, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_GRAVITY, -33554432, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_REST, 33554432, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_GRAVITY, 33554432, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_RELAUNCH, -131072, 131072, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_BOX, 65536, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_RADIUS, 16777216, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_BOUNCE, 65536, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_LAUNCH, 33554432, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_RELAUNCH, -1, 1, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_GRAVITY, -33554432, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_BOUNCE, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_LAUNCH, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_REST, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_RELAUNCH, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TOGGLE, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{1, REG_STEP, 0, OP_TICK, 0, 0, NO_KNOWN},
      '{0, REG_GRAVITY, 0, OP_TICK, 0, 0, NO_KNOWN}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bouncing_ball_box_step u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // ball model state
   cfg_type    regs;
   longint     ball_pos [3];
   longint     ball_vel [3];
   bit         ball_running;
   ball_word_t due_words [$];

   int known_pick = NO_KNOWN;
   bit gaps_on = 1'b1;
   int errors = 0;
   int items_in = 0;
   int results_seen = 0;
   int floor_stops = 0;
   int reg_writes = 0;
   int stall_cycles = 0;

   function automatic longint clamp_l(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_speed(longint v);
      return clamp_l(v, -SPEED_MAX, SPEED_MAX);
   endfunction

   // product scaled down by FRAC, rounded half away from zero
   function automatic longint mul_round(longint a, longint b);
      longint ma, mb, r;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r = (ma * mb + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      return neg ? -r : r;
   endfunction

   function automatic longint bounce(longint v);
      return sat_speed(-mul_round(v, longint'(regs.bounce_factor)));
   endfunction

   function automatic void relaunch_ball(longint vx, longint vy);
      ball_pos[0] = longint'(regs.box_size) >>> 1;
      ball_pos[1] = longint'(regs.box_size) >>> 1;
      ball_pos[2] = longint'(regs.ball_radius) + (longint'(DROP_HEIGHT) <<< FRAC);
      ball_vel[0] = sat_speed(vx);
      ball_vel[1] = sat_speed(vy);
      ball_vel[2] = sat_speed(longint'(regs.launch_speed));
      ball_running = 1'b0;
   endfunction

   // one Euler step with wall checks; returns 1 when the ball stops on the floor
   function automatic bit integrate_tick();
      longint r, box, top, dt, vz_mag;
      int i;
      r = longint'(regs.ball_radius);
      box = longint'(regs.box_size);
      top = box - r < 0 ? 0 : box - r;
      dt = longint'(regs.time_step);
      ball_vel[2] = sat_speed(ball_vel[2] + mul_round(longint'($signed(regs.gravity_accel)), dt));
      for (i = 0; i < 3; i++)
         ball_pos[i] = clamp_l(ball_pos[i] + mul_round(ball_vel[i], dt), POS_LO, POS_HI);
      if (ball_pos[2] < r) begin
         ball_pos[2] = r;
         vz_mag = ball_vel[2] < 0 ? -ball_vel[2] : ball_vel[2];
         if (vz_mag < longint'(regs.rest_speed)) begin
            ball_vel[0] = 0;
            ball_vel[1] = 0;
            ball_vel[2] = 0;
            ball_running = 1'b0;
            return 1'b1;
         end
         ball_vel[2] = bounce(ball_vel[2]);
      end
      if (ball_pos[2] + r > box) begin
         ball_pos[2] = top;
         ball_vel[2] = bounce(ball_vel[2]);
      end
      for (i = 0; i < 2; i++) begin
         if (ball_pos[i] < r) begin
            ball_pos[i] = r;
            ball_vel[i] = bounce(ball_vel[i]);
         end
         if (ball_pos[i] + r > box) begin
            ball_pos[i] = top;
            ball_vel[i] = bounce(ball_vel[i]);
         end
      end
      return 1'b0;
   endfunction

   function automatic ball_word_t advance_ball(logic [OP_W-1:0] op, longint vx, longint vy);
      ball_word_t w;
      bit stopped;
      stopped = 1'b0;
      case (op)
         OP_TICK:     if (ball_running) stopped = integrate_tick();
         OP_TOGGLE:   ball_running = !ball_running;
         OP_RELAUNCH: relaunch_ball(vx, vy);
         default:     ;
      endcase
      w.ball_x = 26'(clamp_l(ball_pos[0], 0, REPORT_MAX));
      w.ball_y = 26'(clamp_l(ball_pos[1], 0, REPORT_MAX));
      w.ball_z = 26'(clamp_l(ball_pos[2], 0, REPORT_MAX));
      w.speed_x = 27'(ball_vel[0]);
      w.speed_y = 27'(ball_vel[1]);
      w.speed_z = 27'(ball_vel[2]);
      w.running = ball_running;
      w.came_to_rest = stopped;
      return w;
   endfunction

   function automatic string diff_fields(ball_word_t e, ball_word_t a);
      string s;
      s = "";
      if (e.ball_x !== a.ball_x)
         s = {s, $sformatf(" ball_x exp %0d got %0d", e.ball_x, a.ball_x)};
      if (e.ball_y !== a.ball_y)
         s = {s, $sformatf(" ball_y exp %0d got %0d", e.ball_y, a.ball_y)};
      if (e.ball_z !== a.ball_z)
         s = {s, $sformatf(" ball_z exp %0d got %0d", e.ball_z, a.ball_z)};
      if (e.speed_x !== a.speed_x)
         s = {s, $sformatf(" speed_x exp %0d got %0d", e.speed_x, a.speed_x)};
      if (e.speed_y !== a.speed_y)
         s = {s, $sformatf(" speed_y exp %0d got %0d", e.speed_y, a.speed_y)};
      if (e.speed_z !== a.speed_z)
         s = {s, $sformatf(" speed_z exp %0d got %0d", e.speed_z, a.speed_z)};
      if (e.running !== a.running)
         s = {s, $sformatf(" running exp %0b got %0b", e.running, a.running)};
      if (e.came_to_rest !== a.came_to_rest)
         s = {s, $sformatf(" came_to_rest exp %0b got %0b", e.came_to_rest, a.came_to_rest)};
      return s;
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10)
         $display("mismatch at result %0d:%s", results_seen, msg);
   endtask

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic longint pick_in(longint lo, longint hi);
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return lo;
      if (p == 1) return hi;
      if (p < 4) return lo + longint'($urandom_range(0, 32'((hi - lo) / 64)));
      return lo + longint'($urandom_range(0, 32'(hi - lo)));
   endfunction

   function automatic logic [LAUNCH_W-1:0] rand_launch();
      return LAUNCH_W'(longint'($urandom_range(0, 262144)) - 131072);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_word(input logic [OP_W-1:0] op, input logic [LAUNCH_W-1:0] vx,
                            input logic [LAUNCH_W-1:0] vy);
      int g;
      g = gaps_on ? idle_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W - 2 * LAUNCH_W){1'b0}}, vy, vx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      case (idx)
         REG_GRAVITY: regs.gravity_accel = v;
         REG_STEP:    regs.time_step = v[16:0];
         REG_BOUNCE:  regs.bounce_factor = v[16:0];
         REG_BOX:     regs.box_size = v[25:0];
         REG_RADIUS:  regs.ball_radius = v[24:0];
         REG_REST:    regs.rest_speed = v[25:0];
         REG_LAUNCH:  regs.launch_speed = v[25:0];
         default:     ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : monitor
      ball_word_t seen, want;
      if (!reset) begin
         stall_cycles++;
         if (req_tvalid && req_tready) begin
            want = advance_ball(req_tuser, longint'($signed(req_tdata[LAUNCH_W-1:0])),
                                longint'($signed(req_tdata[2*LAUNCH_W-1:LAUNCH_W])));
            if (known_pick != NO_KNOWN) want = KNOWN_WORDS[known_pick];
            due_words.push_back(want);
            items_in++;
            stall_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = ball_word_t'(rsp_tdata[RSP_USED_W-1:0]);
            results_seen++;
            stall_cycles = 0;
            if (seen.came_to_rest === 1'b1) floor_stops++;
            if (due_words.size() == 0) begin
               note_error($sformatf(" word with nothing due: %h", seen));
            end else begin
               want = due_words.pop_front();
               if (seen !== want) note_error(diff_fields(want, seen));
            end
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("timeout: no handshake for %0d cycles, %0d results due",
               STALL_LIMIT, due_words.size());
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random stalls, quiet stretches, one long hold-off
   initial begin : sink
      bit held;
      int n;
      held = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && results_seen >= 150) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         n = ((results_seen / 40) % 3 != 2) ? idle_len() : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int i, k, ph, sel;
      longint g, box;
      logic [OP_W-1:0] op;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_TICK;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = REG_GRAVITY;
      csr_wdata = '0;
      regs = CFG_RESET;
      relaunch_ball(0, 0);
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].is_reg) begin
            settle_block();
            write_reg(PLAN[i].addr, PLAN[i].value);
         end else begin
            known_pick = PLAN[i].known;
            push_word(PLAN[i].op, PLAN[i].vx, PLAN[i].vy);
         end
      end
      known_pick = NO_KNOWN;

      for (ph = 0; ph < PHASES; ph++) begin
         settle_block();
         g = pick_in(0, SPEED_MAX);
         write_reg(REG_GRAVITY, CSR_DATA_W'(($urandom_range(0, 4) == 0) ? g : -g));
         write_reg(REG_STEP, CSR_DATA_W'(pick_in(0, 65536)));
         write_reg(REG_BOUNCE, CSR_DATA_W'(pick_in(0, 65536)));
         box = pick_in(65536, SPEED_MAX);
         write_reg(REG_BOX, CSR_DATA_W'(box));
         write_reg(REG_RADIUS, CSR_DATA_W'(($urandom_range(0, 3) == 0) ?
                                           pick_in(0, 16777216) : pick_in(0, box / 8)));
         write_reg(REG_REST, CSR_DATA_W'(pick_in(0, SPEED_MAX)));
         write_reg(REG_LAUNCH, CSR_DATA_W'(pick_in(0, SPEED_MAX)));
         gaps_on = (ph % 3 != 1);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 4 && k == 20) settle_block();
            if (k == 0) begin
               op = OP_RELAUNCH;
            end else if (!ball_running) begin
               sel = $urandom_range(0, 9);
               op = sel < 5 ? OP_TOGGLE : (sel < 8 ? OP_RELAUNCH : (sel < 9 ? OP_TICK : OP_SPARE));
            end else begin
               sel = $urandom_range(0, 15);
               op = sel < 13 ? OP_TICK :
                    (sel == 13 ? OP_TOGGLE : (sel == 14 ? OP_RELAUNCH : OP_SPARE));
            end
            push_word(op, rand_launch(), rand_launch());
         end
      end

      req_tvalid <= 1'b0;
      while (due_words.size() != 0) @(negedge clock);
      repeat (TAIL) @(negedge clock);
      $display("%0d words in, %0d results checked, %0d floor stops", items_in, results_seen,
               floor_stops);
      $display("%0d register writes over the directed table and %0d random settings",
               reg_writes, PHASES);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== bouncing_ball_box_step.f =====
rtl/bbs_pkg.sv
rtl/bbs_csr.sv
rtl/bbs_mul.sv
rtl/bouncing_ball_box_step.sv
rtl/bbs_check.sv
tb/testbench.sv
